>>> design/mrc_pkg.sv
// Shared types, constants and the byte-wide CRC-16 update for the response checker.
package mrc_pkg;

  localparam int unsigned CntW = 9;

  localparam logic [15:0] CrcInit   = 16'hFFFF;
  localparam logic [15:0] CrcPoly   = 16'hA001;
  localparam logic [15:0] CrcLsb    = 16'h0001;
  localparam logic [7:0]  FuncReset = 8'h03;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } beat_t;

  typedef struct packed {
    logic            crc_ok;
    logic            function_ok;
    logic [CntW-1:0] frame_length;
    logic            too_long;
    logic [15:0]     computed_crc;
    logic [15:0]     received_crc;
  } result_t;

  // Reflected CRC-16, one byte, LSB first.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if ((c & CrcLsb) != 16'h0000) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> design/mrc_in_stage.sv
// Input register stage: holds one accepted byte beat until the frame logic takes it.
module mrc_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  mrc_pkg::beat_t beat_i,
  input  logic          take_i,
  output logic          beat_valid_o,
  output mrc_pkg::beat_t beat_o
);

  logic           valid_q, valid_d;
  mrc_pkg::beat_t beat_q;

  assign in_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_valid_i && in_ready_o) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      beat_q <= beat_i;
    end
  end

  assign beat_valid_o = valid_q;
  assign beat_o       = beat_q;

`ifndef NO_ASSERTIONS
  a_take_needs_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take_i |-> valid_q)
    else $error("frame logic took a beat from an empty stage");
  a_hold_when_stuck: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !take_i |=> valid_q && $stable(beat_q))
    else $error("staged beat lost or changed while not taken");
`endif

endmodule

>>> design/mrc_frame.sv
// Frame state (CRC, delay line, count) and the per-beat result computation.
module mrc_frame #(
  parameter int unsigned MAX_FRAME_BYTES = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             beat_valid_i,
  input  mrc_pkg::beat_t   beat_i,
  input  logic             res_free_i,
  input  logic [7:0]       expected_function_i,
  output logic             take_o,
  output logic             res_we_o,
  output mrc_pkg::result_t res_o
);

  localparam logic [mrc_pkg::CntW-1:0] MaxCnt = mrc_pkg::CntW'(MAX_FRAME_BYTES);
  localparam logic [mrc_pkg::CntW-1:0] CntOne = mrc_pkg::CntW'(1);
  localparam logic [mrc_pkg::CntW-1:0] CntTwo = mrc_pkg::CntW'(2);
  localparam logic [mrc_pkg::CntW-1:0] CntFour = mrc_pkg::CntW'(4);

  logic [15:0]               acc_q, acc_d, acc_next;
  logic [7:0]                d0_q, d0_d, d1_q, d1_d;
  logic [7:0]                fb_q, fb_d;
  logic [mrc_pkg::CntW-1:0]  cnt_q, cnt_d, len;
  logic                      ovf_q, ovf_d, ovf_next;
  logic [15:0]               rx_crc;
  logic                      len_ge2;

  // A non-final beat never waits; the final one needs the result register.
  assign take_o   = beat_valid_i && (!beat_i.last_byte || res_free_i);
  assign res_we_o = take_o && beat_i.last_byte;

  always_comb begin
    // oldest delayed byte joins the CRC once two bytes are held
    acc_next = (cnt_q >= CntTwo) ? mrc_pkg::crc_feed(acc_q, d0_q) : acc_q;
    ovf_next = ovf_q || (cnt_q >= MaxCnt);
    len      = (cnt_q >= MaxCnt) ? cnt_q : cnt_q + CntOne;
    len_ge2  = (len >= CntTwo);
    rx_crc   = len_ge2 ? {beat_i.data_byte, d1_q} : 16'h0000;

    res_o.crc_ok       = len_ge2 && (acc_next == rx_crc);
    res_o.function_ok  = (len < CntFour) || (fb_q == expected_function_i);
    res_o.frame_length = len;
    res_o.too_long     = ovf_next;
    res_o.computed_crc = acc_next;
    res_o.received_crc = rx_crc;

    acc_d = acc_q;
    d0_d  = d0_q;
    d1_d  = d1_q;
    fb_d  = fb_q;
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (take_o) begin
      if (cnt_q == CntOne) begin
        fb_d = beat_i.data_byte;
      end
      if (beat_i.last_byte) begin
        acc_d = mrc_pkg::CrcInit;
        d0_d  = 8'h00;
        d1_d  = 8'h00;
        cnt_d = '0;
        ovf_d = 1'b0;
      end else begin
        acc_d = acc_next;
        d0_d  = d1_q;
        d1_d  = beat_i.data_byte;
        cnt_d = len;
        ovf_d = ovf_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q <= mrc_pkg::CrcInit;
      d0_q  <= 8'h00;
      d1_q  <= 8'h00;
      fb_q  <= 8'h00;
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      acc_q <= acc_d;
      d0_q  <= d0_d;
      d1_q  <= d1_d;
      fb_q  <= fb_d;
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_clear_after_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_we_o |=> (cnt_q == '0) && !ovf_q && (acc_q == mrc_pkg::CrcInit))
    else $error("frame state not cleared after final beat");
  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= MaxCnt)
    else $error("byte count beyond maximum");
  a_ovf_at_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> cnt_q == MaxCnt)
    else $error("overflow flag set below maximum count");
`endif

endmodule

>>> design/modbus_rtu_response_checker.sv
// Top level of the Modbus RTU response checker: config register, stages, result register.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------------------
//  in      | input     | in_valid_i/in_ready_o  | data_byte_i, last_byte_i
//  out     | output    | out_valid_o/out_ready_i| crc_ok_o .. received_crc_o (one per frame)
//  cfg     | input     | cfg_valid_i/cfg_ready_o| cfg_expected_function_i
//
//  One byte per cycle unless a stalled result holds back a final beat in the input register.
//  Path: input register -> byte CRC update and compares -> result register.
//  Reset puts the CRC at 0xFFFF, clears count and delay line, expected function 0x03.
//  A stalled result only holds back a final beat; non-final beats keep flowing.
module modbus_rtu_response_checker #(
  parameter int unsigned MAX_FRAME_BYTES = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        crc_ok_o,
  output logic        function_ok_o,
  output logic [8:0]  frame_length_o,
  output logic        too_long_o,
  output logic [15:0] computed_crc_o,
  output logic [15:0] received_crc_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_expected_function_i
);

  logic [7:0]       exp_func_q;
  mrc_pkg::beat_t   in_beat, st_beat;
  logic             st_valid, take, res_we, res_free;
  mrc_pkg::result_t res, res_q;
  logic             out_valid_q, out_valid_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_func_q <= mrc_pkg::FuncReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      exp_func_q <= cfg_expected_function_i;
    end
  end

  assign in_beat.data_byte = data_byte_i;
  assign in_beat.last_byte = last_byte_i;

  mrc_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .beat_i      (in_beat),
    .take_i      (take),
    .beat_valid_o(st_valid),
    .beat_o      (st_beat)
  );

  assign res_free = !out_valid_q || out_ready_i;

  mrc_frame #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_frame (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .beat_valid_i       (st_valid),
    .beat_i             (st_beat),
    .res_free_i         (res_free),
    .expected_function_i(exp_func_q),
    .take_o             (take),
    .res_we_o           (res_we),
    .res_o              (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (res_we) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_we) begin
      res_q <= res;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign crc_ok_o       = res_q.crc_ok;
  assign function_ok_o  = res_q.function_ok;
  assign frame_length_o = res_q.frame_length;
  assign too_long_o     = res_q.too_long;
  assign computed_crc_o = res_q.computed_crc;
  assign received_crc_o = res_q.received_crc;

`ifndef NO_ASSERTIONS
  a_short_no_crc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (frame_length_o < 9'd2) |-> !crc_ok_o && (received_crc_o == 16'h0000))
    else $error("short frame reported a CRC");
  a_short_func_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (frame_length_o < 9'd4) |-> function_ok_o)
    else $error("function check not skipped on short frame");
  a_too_long_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && too_long_o |-> frame_length_o == 9'(MAX_FRAME_BYTES))
    else $error("too-long frame without saturated length");
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !res_we)
    else $error("result register overwritten while stalled");
`endif

endmodule
